// ===== rtl/lbeg_pkg.sv =====
// ----------------------------------------------------------------------------
// lbeg_pkg
// Shared types and constants of the LED brightness effect generator.
// ----------------------------------------------------------------------------
package lbeg_pkg;

  localparam int OP_W        = 3;
  localparam int RND_W       = 16;
  localparam int WLVL_W      = 7;
  localparam int LVL_W       = 8;
  localparam int PERIOD_W    = 16;
  localparam int NOW_W       = 32;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int QUO_W       = 8;
  localparam int CNT_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 8'd240;
  localparam logic [LVL_W-1:0] WRITE_MAX = 8'd127;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LOW    = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  localparam logic [1:0] PH_LOW_HOLD  = 2'd0;
  localparam logic [1:0] PH_RISE      = 2'd1;
  localparam logic [1:0] PH_HIGH_HOLD = 2'd2;
  localparam logic [1:0] PH_FALL      = 2'd3;

  // phase length: base plus sample mod jitter
  localparam logic [10:0] BASE_LONG   = 11'd1000;
  localparam logic [10:0] BASE_SHORT  = 11'd500;
  localparam logic [13:0] JIT_LONG    = 14'd10000;
  localparam logic [13:0] JIT_SHORT   = 14'd1000;
  // floor(x / jitter) == (x * RECIP) >> SHIFT for any 16-bit x
  localparam logic [16:0] RECIP_LONG  = 17'd107375;
  localparam int          SHIFT_LONG  = 30;
  localparam logic [16:0] RECIP_SHORT = 17'd67109;
  localparam int          SHIFT_SHORT = 26;
  localparam int          QM_W        = 33;

  localparam logic [LVL_W-1:0]    LOW_RST    = 8'd32;
  localparam logic [LVL_W-1:0]    HIGH_RST   = 8'd240;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd200;

  typedef enum logic [1:0] {
    MODE_HOLD    = 2'd0,
    MODE_SPARKLE = 2'd1,
    MODE_RAMP    = 2'd2,
    MODE_OFF     = 2'd3
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE,
    OP_HOLD,
    OP_SPARKLE,
    OP_RAMP,
    OP_OFF
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_JIT1,
    ST_JIT2,
    ST_MUL,
    ST_PROD,
    ST_DIV,
    ST_LVL,
    ST_DONE
  } state_t;

  typedef struct packed {
    mode_t                mode;
    logic [LVL_W-1:0]     low;
    logic [LVL_W-1:0]     high;
    logic [PERIOD_W-1:0]  period;
  } cfg_t;

  typedef struct packed {
    logic  wr;
    mode_t mode;
  } mode_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/lbeg_if.sv =====
// ----------------------------------------------------------------------------
// lbeg_if
// Valid/ready channels of the effect generator: input items and results.
// ----------------------------------------------------------------------------
interface lbeg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_ms;
  logic [15:0] rand_sample;
  logic [7:0]  new_level;

  modport source (output valid, kind, now_ms, rand_sample, new_level, input ready);
  modport sink   (input valid, kind, now_ms, rand_sample, new_level, output ready);
endinterface

interface lbeg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] brightness;
  logic       level_changed;
  logic [1:0] sparkle_phase;

  modport source (output valid, brightness, level_changed, sparkle_phase, input ready);
  modport sink   (input valid, brightness, level_changed, sparkle_phase, output ready);
endinterface

// ===== rtl/lbeg_front.sv =====
// ----------------------------------------------------------------------------
// lbeg_front
// Input side: accepts beats, clamps level writes, masks the time and tags
// each item with the operation the back end must run.
// ----------------------------------------------------------------------------
module lbeg_front import lbeg_pkg::*; #(
  parameter int  TIME_WIDTH = 32,
  localparam int CMD_W      = OP_W + TIME_WIDTH + RND_W + WLVL_W
) (
  lbeg_in_if.sink          in_ch,
  input  cfg_t             cfg,
  input  fifo_stat_t       q_stat,
  output logic             push,
  output logic [CMD_W-1:0] push_data
);

  typedef struct packed {
    op_t                   op;
    logic [TIME_WIDTH-1:0] now;
    logic [RND_W-1:0]      rnd;
    logic [WLVL_W-1:0]     wlvl;
  } cmd_t;

  cmd_t        cmd;
  logic [63:0] now_wide;

  assign now_wide = {32'd0, in_ch.now_ms};

  always_comb begin
    cmd.now  = now_wide[TIME_WIDTH-1:0];
    cmd.rnd  = in_ch.rand_sample;
    cmd.wlvl = (in_ch.new_level > WRITE_MAX) ? WLVL_W'(WRITE_MAX)
                                             : in_ch.new_level[WLVL_W-1:0];
    if (in_ch.kind == KIND_WRITE) begin
      cmd.op = OP_WRITE;
    end else begin
      case (cfg.mode)
        MODE_HOLD:    cmd.op = OP_HOLD;
        MODE_SPARKLE: cmd.op = OP_SPARKLE;
        MODE_RAMP:    cmd.op = OP_RAMP;
        default:      cmd.op = OP_OFF;
      endcase
    end
  end

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;
  assign push_data   = cmd;

endmodule

// ===== rtl/lbeg_fifo.sv =====
// ----------------------------------------------------------------------------
// lbeg_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module lbeg_fifo import lbeg_pkg::*; #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_stat_t       stat
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== rtl/lbeg_back.sv =====
// ----------------------------------------------------------------------------
// lbeg_back
// Effect engine: runs one queued command at a time, keeps the effect state
// and the sparkle interpolation divider, and drives the result register.
// ----------------------------------------------------------------------------
module lbeg_back import lbeg_pkg::*; #(
  parameter int  TIME_WIDTH = 32,
  localparam int CMD_W      = OP_W + TIME_WIDTH + RND_W + WLVL_W,
  localparam int PROD_W     = TIME_WIDTH + LVL_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  mode_wr_t         mode_wr,
  input  fifo_stat_t       q_stat,
  output logic             pop,
  input  logic [CMD_W-1:0] pop_data,
  lbeg_out_if.source       out_ch
);

  typedef struct packed {
    op_t                   op;
    logic [TIME_WIDTH-1:0] now;
    logic [RND_W-1:0]      rnd;
    logic [WLVL_W-1:0]     wlvl;
  } cmd_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [LVL_W-1:0]      before_r, before_nxt;
  logic [LVL_W-1:0]      level_r, level_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  logic [TIME_WIDTH-1:0] end_r, end_nxt;
  logic [LVL_W-1:0]      from_r, from_nxt;
  logic [LVL_W-1:0]      to_r, to_nxt;
  logic [TIME_WIDTH-1:0] ramp_last_r, ramp_last_nxt;
  logic [QM_W-1:0]       qm_r, qm_nxt;
  logic [RND_W-1:0]      qj_r, qj_nxt;
  logic [TIME_WIDTH-1:0] delta_r, delta_nxt;
  logic [TIME_WIDTH-1:0] at_r, at_nxt;
  logic [PROD_W-1:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0]     dvs_r, dvs_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [LVL_W-1:0]      bright_r, bright_nxt;
  logic                  changed_r, changed_nxt;
  logic [1:0]            oph_r, oph_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  slot_free;
  logic                  now_gt_end;
  logic [TIME_WIDTH-1:0] delta_w;
  logic [TIME_WIDTH-1:0] at_w;
  logic [TIME_WIDTH-1:0] last_eff;
  logic [TIME_WIDTH:0]   ramp_sum;
  logic                  ramp_step;
  logic [1:0]            ph_adv;
  logic                  up;
  logic [LVL_W-1:0]      span;
  logic [LVL_W:0]        tgt;
  logic [6:0]            q7;
  logic [13:0]           jit_c;
  logic [10:0]           base_c;
  logic [RND_W-1:0]      rnd_mod;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign now_gt_end = cmd_r.now > end_r;
  assign delta_w    = end_r - start_r;
  assign at_w       = cmd_r.now - start_r;
  assign ph_adv     = phase_r + 2'd1;

  // a ramp that never ran starts from the current time
  assign last_eff  = (ramp_last_r == '0) ? cmd_r.now : ramp_last_r;
  assign ramp_sum  = {1'b0, last_eff} + (TIME_WIDTH + 1)'(cfg.period);
  assign ramp_step = !ramp_sum[TIME_WIDTH] && (cmd_r.now >= ramp_sum[TIME_WIDTH-1:0]);

  assign up   = (to_r >= from_r);
  assign span = up ? (to_r - from_r) : (from_r - to_r);

  always_comb begin
    if (phase_r == PH_LOW_HOLD) begin
      q7    = 7'(qm_r >> SHIFT_LONG);
      jit_c = JIT_LONG;
    end else begin
      q7    = 7'(qm_r >> SHIFT_SHORT);
      jit_c = JIT_SHORT;
    end
    base_c  = (phase_r == PH_HIGH_HOLD) ? BASE_SHORT : BASE_LONG;
    rnd_mod = cmd_r.rnd - qj_r;
    // falling phases round the step toward the to level
    if (up) begin
      tgt = {1'b0, from_r} + {1'b0, quo_r};
    end else begin
      tgt = {1'b0, from_r} - {1'b0, quo_r} - (LVL_W + 1)'(rem_r != '0);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_r.op == OP_SPARKLE) begin
          state_nxt = now_gt_end ? ST_JIT1 : ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_JIT1: state_nxt = ST_JIT2;
      ST_JIT2: state_nxt = ST_MUL;
      ST_MUL: begin
        state_nxt = (delta_w == '0) ? ST_DONE : ST_PROD;
      end
      ST_PROD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_LVL;
      end
      ST_LVL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop           = 1'b0;
    cmd_nxt       = cmd_r;
    before_nxt    = before_r;
    level_nxt     = level_r;
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    ramp_last_nxt = ramp_last_r;
    qm_nxt        = qm_r;
    qj_nxt        = qj_r;
    delta_nxt     = delta_r;
    at_nxt        = at_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    bright_nxt    = bright_r;
    changed_nxt   = changed_r;
    oph_nxt       = oph_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          cmd_nxt    = pop_data;
          before_nxt = level_r;
        end
      end
      ST_EXEC: begin
        case (cmd_r.op)
          OP_WRITE: level_nxt = {1'b0, cmd_r.wlvl};
          OP_OFF:   level_nxt = '0;
          OP_RAMP: begin
            ramp_last_nxt = last_eff;
            if (ramp_step) begin
              ramp_last_nxt = ramp_sum[TIME_WIDTH-1:0];
              level_nxt     = (level_r >= LEVEL_MAX) ? '0 : level_r + 1'b1;
            end
          end
          OP_SPARKLE: begin
            if (now_gt_end) begin
              phase_nxt = ph_adv;
              start_nxt = cmd_r.now;
              case (ph_adv)
                PH_LOW_HOLD: begin
                  from_nxt = cfg.low;
                  to_nxt   = cfg.low;
                end
                PH_RISE: begin
                  from_nxt = cfg.low;
                  to_nxt   = cfg.high;
                end
                PH_HIGH_HOLD: begin
                  from_nxt = cfg.high;
                  to_nxt   = cfg.high;
                end
                default: begin
                  from_nxt = cfg.high;
                  to_nxt   = cfg.low;
                end
              endcase
              qm_nxt = QM_W'(cmd_r.rnd) *
                       QM_W'((ph_adv == PH_LOW_HOLD) ? RECIP_LONG : RECIP_SHORT);
            end
          end
          default: ;
        endcase
      end
      ST_JIT1: qj_nxt = RND_W'(q7) * RND_W'(jit_c);
      ST_JIT2: begin
        end_nxt = cmd_r.now + TIME_WIDTH'(base_c) + TIME_WIDTH'(rnd_mod);
      end
      ST_MUL: begin
        delta_nxt = delta_w;
        // saturate a time before the phase start to the phase end
        at_nxt    = (at_w > delta_w) ? delta_w : at_w;
      end
      ST_PROD: begin
        rem_nxt = PROD_W'(at_r) * PROD_W'(span);
        dvs_nxt = PROD_W'(delta_r) << (QUO_W - 1);
        quo_nxt = '0;
        cnt_nxt = CNT_W'(QUO_W - 1);
      end
      ST_DIV: begin
        if (rem_r >= dvs_r) begin
          rem_nxt        = rem_r - dvs_r;
          quo_nxt[cnt_r] = 1'b1;
        end
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      ST_LVL: begin
        level_nxt = (tgt > (LVL_W + 1)'(LEVEL_MAX)) ? LEVEL_MAX : tgt[LVL_W-1:0];
      end
      ST_DONE: begin
        if (slot_free) begin
          bright_nxt    = level_r;
          changed_nxt   = (level_r != before_r);
          oph_nxt       = phase_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // a sparkle or ramp mode write restarts that mode's effect
    if (mode_wr.wr) begin
      if (mode_wr.mode == MODE_SPARKLE) begin
        phase_nxt = PH_FALL;
        end_nxt   = '0;
      end else if (mode_wr.mode == MODE_RAMP) begin
        ramp_last_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      phase_r     <= PH_FALL;
      start_r     <= '0;
      end_r       <= '0;
      from_r      <= '0;
      to_r        <= '0;
      ramp_last_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      ramp_last_r <= ramp_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    before_r  <= before_nxt;
    qm_r      <= qm_nxt;
    qj_r      <= qj_nxt;
    delta_r   <= delta_nxt;
    at_r      <= at_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    bright_r  <= bright_nxt;
    changed_r <= changed_nxt;
    oph_r     <= oph_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.brightness    = bright_r;
  assign out_ch.level_changed = changed_r;
  assign out_ch.sparkle_phase = oph_r;

endmodule

// ===== rtl/led_brightness_effect_generator.sv =====
// ----------------------------------------------------------------------------
// led_brightness_effect_generator
// One-channel LED brightness engine with hold, sparkle, ramp and off modes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per beat: a time tick (kind 0, now_ms and
//   rand_sample) or a manual level write (kind 1, new_level). Every item
//   gives exactly one result beat on out_ch: brightness, level_changed and
//   the stored sparkle_phase.
//   Items land in a two-entry queue; the effect engine takes one at a time.
//   From queue head to result, writes and hold, off and ramp ticks pass
//   the idle, execute and done states. A sparkle tick adds the jitter
//   states when it starts a new phase, then the multiply state, and then
//   the product, divide and level states unless the phase has zero length.
//   The engine takes the next item only once it is back in idle; the
//   interpolation divider retires one quotient bit per cycle.
//   Registers (APB, one word each at 4*i): effect_mode, low_level,
//   high_level, ramp_period_ms. Write them only while the block is idle.
//   Reset loads sparkle mode, low 32, high 240, period 200 and level 0.
//   When out_ch stalls, the result register holds; the engine finishes its
//   next item and waits, and in_ch takes beats until the queue is full.
// ----------------------------------------------------------------------------
module led_brightness_effect_generator import lbeg_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  lbeg_in_if.sink           in_ch,
  lbeg_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CMD_W = OP_W + TIME_WIDTH + RND_W + WLVL_W;

  mode_t                mode_r, mode_nxt;
  logic [LVL_W-1:0]     low_r, low_nxt;
  logic [LVL_W-1:0]     high_r, high_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;

  logic                 wr_en;
  logic [1:0]           reg_idx;
  cfg_t                 cfg;
  mode_wr_t             mode_wr;
  fifo_stat_t           q_stat;
  logic                 push;
  logic                 pop;
  logic [CMD_W-1:0]     push_data;
  logic [CMD_W-1:0]     pop_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    mode_nxt   = mode_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    period_nxt = period_r;
    if (wr_en) begin
      case (reg_idx)
        REG_MODE:   mode_nxt   = mode_t'(pwdata[1:0]);
        REG_LOW:    low_nxt    = pwdata[LVL_W-1:0];
        REG_HIGH:   high_nxt   = pwdata[LVL_W-1:0];
        REG_PERIOD: period_nxt = pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SPARKLE;
      low_r    <= LOW_RST;
      high_r   <= HIGH_RST;
      period_r <= PERIOD_RST;
    end else begin
      mode_r   <= mode_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      period_r <= period_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:   prdata = DATA_W'(mode_r);
      REG_LOW:    prdata = DATA_W'(low_r);
      REG_HIGH:   prdata = DATA_W'(high_r);
      REG_PERIOD: prdata = DATA_W'(period_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.mode     = mode_r;
  assign cfg.low      = low_r;
  assign cfg.high     = high_r;
  assign cfg.period   = period_r;
  assign mode_wr.wr   = wr_en && (reg_idx == REG_MODE);
  assign mode_wr.mode = mode_t'(pwdata[1:0]);

  lbeg_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  lbeg_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  lbeg_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .mode_wr  (mode_wr),
    .q_stat   (q_stat),
    .pop      (pop),
    .pop_data (pop_data),
    .out_ch   (out_ch)
  );

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.brightness <= LEVEL_MAX))
    else $error("brightness above the level limit");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_stat.empty)
    else $error("queue empty after a push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("engine popped an empty queue");

endmodule

// ===== verif/tb_led_brightness_effect_generator.sv =====
// ----------------------------------------------------------------------------
// tb_led_brightness_effect_generator
// Self-checking bench for the LED brightness effect generator. An input
// driver and a result checker run as clocked processes with random gaps and
// stalls. A local brightness predictor tracks level, sparkle phase and ramp
// timing and forms one expected beat per accepted item. Registers are set
// over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_led_brightness_effect_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import lbeg_pkg::*;

  typedef struct {
    logic        kind;
    logic [31:0] now_ms;
    logic [15:0] rnd;
    logic [7:0]  new_level;
  } led_item_t;

  typedef struct {
    logic [7:0] brightness;
    logic       changed;
    logic [1:0] phase;
  } led_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lbeg_in_if  in_ch ();
  lbeg_out_if out_ch ();

  led_brightness_effect_generator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and effect state
  mode_t       cfg_mode;
  logic [7:0]  cfg_low;
  logic [7:0]  cfg_high;
  logic [15:0] cfg_period;
  logic [7:0]  lvl;
  logic [1:0]  ph;
  logic [31:0] ph_start;
  logic [31:0] ph_end;
  logic [7:0]  ph_from;
  logic [7:0]  ph_to;
  logic [31:0] ramp_last;

  led_item_t   item_q[$];
  led_result_t brightness_q[$];
  int          mismatches = 0;
  int          sent = 0;
  bit          in_beat = 1'b0;
  bit          out_beat = 1'b0;
  bit          no_idle = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;

  function automatic void sparkle_advance(logic [31:0] now, logic [15:0] rnd);
    logic [63:0] base;
    logic [63:0] jit;
    logic [63:0] dlt;
    logic [63:0] at;
    logic [63:0] tgt;
    logic [31:0] d32;
    logic [31:0] a32;
    if (now > ph_end) begin
      ph = ph + 2'd1;
      ph_start = now;
      base = 64'd1000;
      jit = 64'd1000;
      case (ph)
        PH_LOW_HOLD: begin
          ph_from = cfg_low;
          ph_to = cfg_low;
          jit = 64'd10000;
        end
        PH_RISE: begin
          ph_from = cfg_low;
          ph_to = cfg_high;
        end
        PH_HIGH_HOLD: begin
          ph_from = cfg_high;
          ph_to = cfg_high;
          base = 64'd500;
        end
        default: begin
          ph_from = cfg_high;
          ph_to = cfg_low;
        end
      endcase
      ph_end = 32'(64'(now) + base + 64'(rnd) % jit);
    end
    d32 = ph_end - ph_start;
    a32 = now - ph_start;
    dlt = 64'(d32);
    at = 64'(a32);
    // zero-length phase leaves the level alone
    if (dlt == 64'd0) return;
    // time before the phase start saturates to the end level
    if (at > dlt) at = dlt;
    if (ph_to >= ph_from) tgt = 64'(ph_from) + at * 64'(ph_to - ph_from) / dlt;
    else tgt = 64'(ph_from) - (at * 64'(ph_from - ph_to) + dlt - 64'd1) / dlt;
    lvl = (tgt > 64'(LEVEL_MAX)) ? LEVEL_MAX : tgt[7:0];
  endfunction

  function automatic void ramp_advance(logic [31:0] now);
    logic [32:0] sum;
    if (ramp_last == 32'd0) ramp_last = now;
    sum = {1'b0, ramp_last} + 33'(cfg_period);
    // a sum past the time width never steps
    if (!sum[32] && now >= sum[31:0]) begin
      ramp_last = sum[31:0];
      lvl = (lvl >= LEVEL_MAX) ? 8'd0 : lvl + 8'd1;
    end
  endfunction

  function automatic led_result_t next_brightness(led_item_t it);
    led_result_t r;
    logic [7:0]  prev;
    prev = lvl;
    if (it.kind == KIND_WRITE) begin
      lvl = (it.new_level > WRITE_MAX) ? WRITE_MAX : it.new_level;
    end else begin
      case (cfg_mode)
        MODE_HOLD:    ;
        MODE_SPARKLE: sparkle_advance(it.now_ms, it.rnd);
        MODE_RAMP:    ramp_advance(it.now_ms);
        default:      lvl = 8'd0;
      endcase
    end
    r.brightness = lvl;
    r.changed = (lvl != prev);
    r.phase = ph;
    return r;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_MODE: begin
        cfg_mode = mode_t'(val[1:0]);
        if (cfg_mode == MODE_SPARKLE) begin
          ph = PH_FALL;
          ph_end = 32'd0;
        end else if (cfg_mode == MODE_RAMP) begin
          ramp_last = 32'd0;
        end
      end
      REG_LOW:  cfg_low = val[7:0];
      REG_HIGH: cfg_high = val[7:0];
      default:  cfg_period = val[15:0];
    endcase
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_MODE: return {30'd0, cfg_mode};
      REG_LOW:  return {24'd0, cfg_low};
      REG_HIGH: return {24'd0, cfg_high};
      default:  return {16'd0, cfg_period};
    endcase
  endfunction

  function automatic void push_tick(logic [31:0] now, logic [15:0] rnd);
    led_item_t it;
    it.kind = KIND_TICK;
    it.now_ms = now;
    it.rnd = rnd;
    it.new_level = 8'($urandom_range(0, 255));
    item_q.push_back(it);
    sent++;
  endfunction

  function automatic void push_write(logic [7:0] v);
    led_item_t it;
    it.kind = KIND_WRITE;
    it.now_ms = $urandom;
    it.rnd = 16'($urandom_range(0, 65535));
    it.new_level = v;
    item_q.push_back(it);
    sent++;
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd240;
      2:       return $urandom_range(241, 255);
      default: return $urandom_range(0, 240);
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd65535;
      2:       return 32'd1;
      3:       return $urandom_range(0, 65535);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // hold until every queued item went in and every result came back
  task automatic drain();
    while (item_q.size() != 0 || in_ch.valid || brightness_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] rd;
    drain();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, val);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== reg_value(idx)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, reg_value(idx), rd);
      mismatches++;
    end
  endtask

  // sample both channels, check result beats, predict accepted items
  always @(posedge clk) begin
    led_item_t   it;
    led_result_t want;
    in_beat = rst_n && in_ch.valid && in_ch.ready;
    out_beat = rst_n && out_ch.valid && out_ch.ready;
    if (out_beat) begin
      if (brightness_q.size() == 0) begin
        $error("result beat with nothing expected: brightness %0d", out_ch.brightness);
        mismatches++;
      end else begin
        want = brightness_q.pop_front();
        if (out_ch.brightness !== want.brightness) begin
          $error("brightness: expected %0d, got %0d", want.brightness, out_ch.brightness);
          mismatches++;
        end
        if (out_ch.level_changed !== want.changed) begin
          $error("level_changed: expected %0d, got %0d", want.changed, out_ch.level_changed);
          mismatches++;
        end
        if (out_ch.sparkle_phase !== want.phase) begin
          $error("sparkle_phase: expected %0d, got %0d", want.phase, out_ch.sparkle_phase);
          mismatches++;
        end
      end
    end
    if (in_beat) begin
      it.kind = in_ch.kind;
      it.now_ms = in_ch.now_ms;
      it.rnd = in_ch.rand_sample;
      it.new_level = in_ch.new_level;
      brightness_q.push_back(next_brightness(it));
    end
  end

  // input driver: advance once the current beat is taken, then wait the drawn gap
  always @(negedge clk) begin
    led_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_beat || !in_ch.valid) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (item_q.size() != 0) begin
        it = item_q.pop_front();
        in_ch.kind <= it.kind;
        in_ch.now_ms <= it.now_ms;
        in_ch.rand_sample <= it.rnd;
        in_ch.new_level <= it.new_level;
        in_ch.valid <= 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 15);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: stall a drawn number of cycles after each beat
  always @(negedge clk) begin
    if (out_beat) out_stall = no_idle ? 0 : $urandom_range(0, 15);
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          seg;
    int          n;
    int          k;
    int          r;
    logic [31:0] t;
    mode_t       m;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_TICK;
    in_ch.now_ms = '0;
    in_ch.rand_sample = '0;
    in_ch.new_level = '0;
    out_ch.ready = 1'b0;
    cfg_mode = MODE_SPARKLE;
    cfg_low = 8'd32;
    cfg_high = 8'd240;
    cfg_period = 16'd200;
    lvl = 8'd0;
    ph = PH_FALL;
    ph_start = 32'd0;
    ph_end = 32'd0;
    ph_from = 8'd0;
    ph_to = 8'd0;
    ramp_last = 32'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sparkle from reset: zero-length phase, clamped writes, phase start,
    // tick before the phase start, rise interpolation
    push_tick(32'd0, 16'd0);
    push_write(8'd255);
    push_write(8'd0);
    push_write(8'd127);
    push_tick(32'd5, 16'hFFFF);
    push_tick(32'd3, 16'd0);
    push_tick(32'd6541, 16'd0);
    push_tick(32'd7000, 16'h8000);
    // high level above the ceiling clamps
    set_reg(REG_HIGH, 32'd255);
    push_tick(32'd7542, 16'h1234);
    // ramp wraps from the ceiling to zero, steps at the top of time
    set_reg(REG_PERIOD, 32'd1);
    set_reg(REG_MODE, 32'(MODE_RAMP));
    push_tick(32'd10, 16'd0);
    push_tick(32'd11, 16'd0);
    push_tick(32'd0, 16'd0);
    push_tick(32'hFFFF_FFFF, 16'd0);
    // ramp sum past the time width never steps
    set_reg(REG_PERIOD, 32'hFFFF);
    set_reg(REG_MODE, 32'(MODE_RAMP));
    push_tick(32'hFFFF_FF00, 16'd0);
    push_tick(32'hFFFF_FFFF, 16'd0);
    // zero period
    set_reg(REG_PERIOD, 32'd0);
    push_tick(32'd100, 16'd0);
    push_tick(32'hFFFF_FFFF, 16'd0);
    push_tick(32'hFFFF_FFFF, 16'd0);
    set_reg(REG_MODE, 32'(MODE_HOLD));
    push_tick(32'd5, 16'd0);
    push_write(8'd60);
    push_tick(32'd6, 16'd0);
    set_reg(REG_MODE, 32'(MODE_OFF));
    push_tick(32'd7, 16'd0);
    push_write(8'd200);
    push_tick(32'd8, 16'd0);

    seg = 0;
    while (sent < 1300) begin
      r = $urandom_range(0, 99);
      if (r < 40) m = MODE_SPARKLE;
      else if (r < 75) m = MODE_RAMP;
      else if (r < 85) m = MODE_HOLD;
      else m = MODE_OFF;
      if (seg == 0 || $urandom_range(0, 1)) set_reg(REG_LOW, pick_level());
      if (seg == 0 || $urandom_range(0, 1)) set_reg(REG_HIGH, pick_level());
      if (seg == 0 || $urandom_range(0, 1)) set_reg(REG_PERIOD, pick_period());
      set_reg(REG_MODE, 32'(m));
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       t = 32'd0;
        1:       t = 32'hFFFF_FFFF - $urandom_range(0, 30000);
        2:       t = $urandom_range(0, 5000);
        default: t = $urandom;
      endcase
      n = $urandom_range(30, 110);
      for (k = 0; k < n; k++) begin
        // hold the sender mid-phase until every result is back
        if (k == n / 2 && (seg == 0 || $urandom_range(0, 3) == 0)) drain();
        r = $urandom_range(0, 99);
        if (r < 10) begin
          push_write(8'($urandom_range(0, 255)));
        end else if (r < 14) begin
          push_tick($urandom, 16'($urandom_range(0, 65535)));
        end else begin
          if (r < 17) t = t - $urandom_range(0, 3000);
          else if (m == MODE_RAMP) t = t + $urandom_range(0, 2 * cfg_period + 2);
          else t = t + $urandom_range(0, 900);
          push_tick(t, 16'($urandom_range(0, 65535)));
        end
      end
      seg++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
